// ===== rtl/adsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR envelope package
// Widths, codes, reset values and shared types of the linear ADSR envelope.
// ----------------------------------------------------------------------------
package adsr_pkg;

    localparam int FRAC_BITS   = 24;
    localparam int LEVEL_W     = 25;
    localparam int OP_W        = 3;
    localparam int PHASE_W     = 3;
    localparam int CFG_INDEX_W = 2;

    localparam int S_TDATA_W = ((OP_W + LEVEL_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((LEVEL_W + PHASE_W + 7) / 8) * 8;

    typedef logic [LEVEL_W-1:0] level_t;

    localparam level_t LEVEL_MAX   = '1;
    localparam level_t UNITY_LEVEL = (FRAC_BITS >= LEVEL_W) ? LEVEL_MAX
                                                            : (level_t'(1) << FRAC_BITS);

    localparam level_t ATTACK_STEP_RST  = level_t'(16777);
    localparam level_t DECAY_STEP_RST   = level_t'(16777);
    localparam level_t SUSTAIN_RST      = level_t'(8388608);
    localparam level_t RELEASE_STEP_RST = level_t'(167772);

    typedef enum logic [PHASE_W-1:0] {
        PH_ATTACK  = 3'd0,
        PH_DECAY   = 3'd1,
        PH_SUSTAIN = 3'd2,
        PH_RELEASE = 3'd3,
        PH_DONE    = 3'd4
    } phase_t;

    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 3'd0,
        OP_KEY_ON     = 3'd1,
        OP_KEY_OFF    = 3'd2,
        OP_SET_TARGET = 3'd3,
        OP_SET_VALUE  = 3'd4
    } opcode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ATTACK_STEP  = 2'd0,
        CFG_DECAY_STEP   = 2'd1,
        CFG_SUSTAIN      = 2'd2,
        CFG_RELEASE_STEP = 2'd3
    } cfg_index_t;

    typedef struct packed {
        level_t current_level;
        level_t target_level;
        level_t active_step;
        level_t working_sustain;
        phase_t phase;
    } env_state_t;

    typedef struct packed {
        level_t attack_step;
        level_t decay_step;
        level_t release_step;
    } env_cfg_t;

endpackage

// ===== rtl/adsr_next_state.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR next-state logic
// Computes the envelope state after one opcode, in a single combinational pass.
// ----------------------------------------------------------------------------
module adsr_next_state (
    input  adsr_pkg::env_state_t               state,
    input  adsr_pkg::env_cfg_t                 cfg,
    input  logic [adsr_pkg::OP_W-1:0]          opcode,
    input  logic [adsr_pkg::LEVEL_W-1:0]       operand,
    output adsr_pkg::env_state_t               state_next
);
    import adsr_pkg::*;

    logic [LEVEL_W:0] attack_sum;
    logic [LEVEL_W:0] decay_floor;
    level_t           decay_diff;
    level_t           release_diff;

    assign attack_sum   = {1'b0, state.current_level} + {1'b0, state.active_step};
    assign decay_floor  = {1'b0, state.working_sustain} + {1'b0, cfg.decay_step};
    assign decay_diff   = state.current_level - cfg.decay_step;
    assign release_diff = state.current_level - cfg.release_step;

    always_comb
    begin
        state_next = state;
        unique case (opcode)
            OP_TICK:
            begin
                case (state.phase)
                    PH_ATTACK:
                    begin
                        // Reaching the target hands over to decay toward sustain.
                        if (attack_sum >= {1'b0, state.target_level})
                        begin
                            state_next.current_level = state.target_level;
                            state_next.active_step   = cfg.decay_step;
                            state_next.target_level  = state.working_sustain;
                            state_next.phase         = PH_DECAY;
                        end
                        else
                        begin
                            state_next.current_level = attack_sum[LEVEL_W-1:0];
                        end
                    end
                    PH_DECAY:
                    begin
                        // Also snaps a level that is already below sustain up to it.
                        if ({1'b0, state.current_level} <= decay_floor)
                        begin
                            state_next.current_level = state.working_sustain;
                            state_next.active_step   = '0;
                            state_next.phase         = PH_SUSTAIN;
                        end
                        else
                        begin
                            state_next.current_level = decay_diff;
                        end
                    end
                    PH_RELEASE:
                    begin
                        if (state.current_level <= cfg.release_step)
                        begin
                            state_next.current_level = '0;
                            state_next.phase         = PH_DONE;
                        end
                        else
                        begin
                            state_next.current_level = release_diff;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_KEY_ON:
            begin
                state_next.target_level = UNITY_LEVEL;
                state_next.active_step  = cfg.attack_step;
                state_next.phase        = PH_ATTACK;
            end
            OP_KEY_OFF:
            begin
                state_next.target_level = '0;
                state_next.active_step  = cfg.release_step;
                state_next.phase        = PH_RELEASE;
            end
            OP_SET_TARGET:
            begin
                state_next.target_level = operand;
                if (state.current_level < operand)
                begin
                    state_next.phase           = PH_ATTACK;
                    state_next.working_sustain = operand;
                    state_next.active_step     = cfg.attack_step;
                end
                else if (state.current_level > operand)
                begin
                    state_next.phase           = PH_DECAY;
                    state_next.working_sustain = operand;
                    state_next.active_step     = cfg.decay_step;
                end
            end
            OP_SET_VALUE:
            begin
                state_next.phase           = PH_SUSTAIN;
                state_next.target_level    = operand;
                state_next.current_level   = operand;
                state_next.working_sustain = operand;
                state_next.active_step     = '0;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== rtl/adsr_envelope_generator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR envelope generator core
// Linear attack/decay/sustain/release envelope driven by a stream of opcodes.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat on the s_ channel carries an opcode (tick, key on, key off,
// set target, set value) and an operand level. Every accepted beat produces
// exactly one output beat on the m_ channel with the envelope level and phase
// after that opcode. Levels are unsigned with 24 fraction bits (1.0 = 2^24).
// The cfg channel writes the four rate/level registers; it is always ready
// and should only be used while no beats are in flight.
// A beat accepted at one edge shows up on m_tvalid right after it.
// Throughput is one beat per cycle unless the receiver stalls; the envelope
// state is updated by a single add-and-compare pass at the accept edge, and
// that state loop is what sets the rate.
// If the receiver stalls, the result waits in the output register; a new
// input beat is still taken in the cycle the result is taken, so s_tready is
// low only while a result is held and m_tready is low.
// Reset clears the envelope to level zero in the attack phase, loads the
// default rates, and empties the output register.
// ----------------------------------------------------------------------------
module adsr_envelope_generator_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // s_tdata: [2:0] opcode, [27:3] operand_level, upper bits zero.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [adsr_pkg::S_TDATA_W-1:0]      s_tdata,
    // m_tdata: [24:0] level, [27:25] phase, upper bits zero.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [adsr_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [adsr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [adsr_pkg::LEVEL_W-1:0]        cfg_data
);
    import adsr_pkg::*;

    // Envelope state and the rate registers.
    env_state_t state_reg;
    env_state_t state_next;
    env_state_t state_calc;
    env_cfg_t   cfg_reg;
    env_cfg_t   cfg_next;

    // Output register.
    logic       m_tvalid_reg;
    logic       m_tvalid_next;
    level_t     m_level_reg;
    level_t     m_level_next;
    phase_t     m_phase_reg;
    phase_t     m_phase_next;

    logic       in_fire;
    logic       cfg_fire;
    logic [OP_W-1:0] in_opcode;
    level_t     in_operand;

    assign in_opcode  = s_tdata[OP_W-1:0];
    assign in_operand = s_tdata[OP_W +: LEVEL_W];

    // The output register frees itself in the same cycle it is drained.
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid;

    adsr_next_state u_next_state (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .opcode     (in_opcode),
        .operand    (in_operand),
        .state_next (state_calc)
    );

    always_comb
    begin
        cfg_next   = cfg_reg;
        state_next = in_fire ? state_calc : state_reg;
        if (cfg_fire)
        begin
            unique case (cfg_index)
                CFG_ATTACK_STEP:  cfg_next.attack_step  = cfg_data;
                CFG_DECAY_STEP:   cfg_next.decay_step   = cfg_data;
                // Writing the sustain level loads the working copy in the envelope state.
                CFG_SUSTAIN:      state_next.working_sustain = cfg_data;
                CFG_RELEASE_STEP: cfg_next.release_step = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_level_next  = m_level_reg;
        m_phase_next  = m_phase_reg;
        if (in_fire)
        begin
            m_tvalid_next = 1'b1;
            m_level_next  = state_calc.current_level;
            m_phase_next  = state_calc.phase;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.current_level   <= '0;
            state_reg.target_level    <= '0;
            state_reg.active_step     <= '0;
            state_reg.working_sustain <= SUSTAIN_RST;
            state_reg.phase           <= PH_ATTACK;
            cfg_reg.attack_step       <= ATTACK_STEP_RST;
            cfg_reg.decay_step        <= DECAY_STEP_RST;
            cfg_reg.release_step      <= RELEASE_STEP_RST;
            m_tvalid_reg              <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cfg_reg      <= cfg_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_level_reg <= m_level_next;
        m_phase_reg <= m_phase_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - LEVEL_W - PHASE_W){1'b0}}, m_phase_reg, m_level_reg};

    // The envelope only reaches done by clamping the release at zero.
    a_done_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_DONE |-> state_reg.current_level == '0)
        else $error("done phase with nonzero level");

    // Sustain is entered only with the step cleared.
    a_sustain_no_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_SUSTAIN |-> state_reg.active_step == '0)
        else $error("sustain phase with nonzero active step");

    // Every accepted beat leaves a result waiting in the next cycle.
    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> m_tvalid_reg)
        else $error("accepted beat produced no result");

    // An empty output register never blocks the input side.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid_reg |-> s_tready)
        else $error("input stalled with empty output register");

endmodule

// ===== tb/adsr_envelope_generator_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR envelope generator core testbench
// Drives opcode beats into the envelope core and checks every output beat
// against a cycle-free envelope predictor. The run starts with a short
// directed pass over each opcode and each phase change. Long randomized
// note sequences follow, with register rewrites between them, under three
// mixes of sender and receiver idling.
// ----------------------------------------------------------------------------
module adsr_envelope_generator_core_test;

    import adsr_pkg::*;

    // Full scale (1.0) and the level that key on aims for. The key-on level
    // is pinned to the largest code when 1.0 does not fit the level width.
    localparam level_t ONE_LEVEL     = level_t'(1) << FRAC_BITS;
    localparam level_t KEY_ON_TARGET = (FRAC_BITS >= LEVEL_W) ? LEVEL_MAX : ONE_LEVEL;

    // Opcodes above set value carry no meaning and leave the envelope alone.
    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned MAX_REPORTED    = 10;
    localparam int unsigned END_DRAIN_TICKS = 4;

    typedef struct packed {
        level_t level;
        phase_t phase;
    } envelope_out_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [LEVEL_W-1:0]     cfg_data;

    // Predicted register contents of the block.
    level_t cfg_attack  = ATTACK_STEP_RST;
    level_t cfg_decay   = DECAY_STEP_RST;
    level_t cfg_release = RELEASE_STEP_RST;

    // Predicted envelope state, starting from the reset values.
    level_t env_level   = '0;
    level_t env_target  = '0;
    level_t env_step    = '0;
    level_t env_sustain = SUSTAIN_RST;
    phase_t env_phase   = PH_ATTACK;

    // Output beats that the block still owes, oldest first.
    envelope_out_t expected_envelope[$];

    int unsigned sender_idle_pct   = 0;
    int unsigned receiver_idle_pct = 0;
    int unsigned commands_sent     = 0;
    int unsigned results_checked   = 0;
    int unsigned register_writes   = 0;
    int unsigned failures          = 0;
    int unsigned cycle_count       = 0;

    adsr_envelope_generator_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock. It starts low, so the first rising edge is at 5 ns.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one command to the predicted state and returns the level and
    // phase that the block must report for it. Sums are kept one bit wider
    // than a level so that attack overshoot and decay underflow compare
    // exactly.
    function automatic envelope_out_t advance_envelope(input logic [OP_W-1:0] op,
                                                       input level_t operand);
        logic [LEVEL_W:0] sum;
        envelope_out_t    out;
        case (op)
            OP_TICK:
            begin
                case (env_phase)
                    PH_ATTACK:
                    begin
                        sum = {1'b0, env_level} + {1'b0, env_step};
                        if (sum >= {1'b0, env_target})
                        begin
                            // Target reached: clamp and head for sustain.
                            env_level  = env_target;
                            env_step   = cfg_decay;
                            env_target = env_sustain;
                            env_phase  = PH_DECAY;
                        end
                        else
                        begin
                            env_level = sum[LEVEL_W-1:0];
                        end
                    end
                    PH_DECAY:
                    begin
                        // Also snaps the level up when it already sits below
                        // the sustain level.
                        if ({1'b0, env_level} <= {1'b0, env_sustain} + {1'b0, cfg_decay})
                        begin
                            env_level = env_sustain;
                            env_step  = '0;
                            env_phase = PH_SUSTAIN;
                        end
                        else
                        begin
                            env_level = env_level - cfg_decay;
                        end
                    end
                    PH_RELEASE:
                    begin
                        if (env_level <= cfg_release)
                        begin
                            env_level = '0;
                            env_phase = PH_DONE;
                        end
                        else
                        begin
                            env_level = env_level - cfg_release;
                        end
                    end
                    default:
                    begin
                        // Sustain and done hold still.
                    end
                endcase
            end
            OP_KEY_ON:
            begin
                env_target = KEY_ON_TARGET;
                env_step   = cfg_attack;
                env_phase  = PH_ATTACK;
            end
            OP_KEY_OFF:
            begin
                env_target = '0;
                env_step   = cfg_release;
                env_phase  = PH_RELEASE;
            end
            OP_SET_TARGET:
            begin
                env_target = operand;
                if (env_level < operand)
                begin
                    env_phase   = PH_ATTACK;
                    env_sustain = operand;
                    env_step    = cfg_attack;
                end
                else if (env_level > operand)
                begin
                    env_phase   = PH_DECAY;
                    env_sustain = operand;
                    env_step    = cfg_decay;
                end
            end
            OP_SET_VALUE:
            begin
                env_phase   = PH_SUSTAIN;
                env_target  = operand;
                env_level   = operand;
                env_sustain = operand;
                env_step    = '0;
            end
            default:
            begin
                // Unused opcodes only echo the present level and phase.
            end
        endcase
        out.level = env_level;
        out.phase = env_phase;
        return out;
    endfunction

    // Random level from zero to 1.0, with both ends drawn often.
    function automatic level_t random_level();
        case ($urandom_range(9))
            0:       return '0;
            1:       return ONE_LEVEL;
            default: return level_t'($urandom_range(0, ONE_LEVEL));
        endcase
    endfunction

    // Random rate. Mostly coarse steps so that notes pass through every
    // phase in a few ticks; zero, full scale and tiny steps show up too.
    function automatic level_t random_rate();
        case ($urandom_range(7))
            0:       return '0;
            1:       return ONE_LEVEL;
            2:       return level_t'($urandom_range(1, 64));
            3:       return level_t'($urandom_range(0, ONE_LEVEL));
            default: return level_t'($urandom_range(ONE_LEVEL / 32, ONE_LEVEL / 2));
        endcase
    endfunction

    // Sends one command beat. Before valid goes up the sender may idle for
    // a random number of cycles. The beat is taken at the first rising edge
    // with s_tready high, and its prediction is queued right there.
    task automatic send_command(input logic [OP_W-1:0] op, input level_t operand);
        logic [S_TDATA_W-1:0] beat;
        beat = '0;
        beat[OP_W-1:0]      = op;
        beat[OP_W +: LEVEL_W] = operand;
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        do
            @(posedge clk);
        while (!s_tready);
        expected_envelope.push_back(advance_envelope(op, operand));
        if (op <= OP_SET_VALUE)
            commands_sent++;
    endtask

    // Drops valid and waits until every owed output beat has been taken.
    // Each command yields exactly one beat, so an empty queue means idle.
    task automatic wait_until_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_envelope.size() != 0)
            @(posedge clk);
    endtask

    // Writes one register while the envelope is idle and mirrors the write
    // in the predicted configuration.
    task automatic write_register(input cfg_index_t idx, input level_t value);
        wait_until_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_ATTACK_STEP:  cfg_attack  = value;
            CFG_DECAY_STEP:   cfg_decay   = value;
            // Writing sustain also reloads the working sustain level.
            CFG_SUSTAIN:      env_sustain = value;
            CFG_RELEASE_STEP: cfg_release = value;
            default:          ;
        endcase
        register_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_settings(input level_t attack, input level_t decay,
                                 input level_t sustain, input level_t release_rate);
        write_register(CFG_ATTACK_STEP, attack);
        write_register(CFG_DECAY_STEP, decay);
        write_register(CFG_SUSTAIN, sustain);
        write_register(CFG_RELEASE_STEP, release_rate);
    endtask

    // Right after reset, with the default rates: the first tick sees level
    // and target both zero, so attack ends at once. The next tick finds the
    // level below sustain and snaps it up.
    task automatic test_reset_state();
        send_command(OP_TICK, '0);
        send_command(OP_TICK, ONE_LEVEL);
        send_command(OP_KEY_ON, '0);
        send_command(OP_TICK, '0);
        send_command(OP_KEY_OFF, '0);
        send_command(OP_TICK, '0);
    endtask

    // One pass over every opcode and phase change, with rates chosen so that
    // each phase ends within a tick or two.
    task automatic test_directed_ops();
        logic [OP_W-1:0] op;
        load_settings(ONE_LEVEL / 2, ONE_LEVEL / 2, ONE_LEVEL / 2, ONE_LEVEL);
        send_command(OP_SET_VALUE, '0);
        // A full note: two attack steps, the last one clamped to 1.0, then
        // two decay steps down to the sustain level, which set value left
        // at zero.
        send_command(OP_KEY_ON, '0);
        send_command(OP_TICK, '0);
        send_command(OP_TICK, '0);
        send_command(OP_TICK, '0);
        send_command(OP_TICK, '0);
        // New target above the level: attack back up, then settle.
        send_command(OP_SET_TARGET, ONE_LEVEL / 4 * 3);
        send_command(OP_TICK, '0);
        send_command(OP_TICK, '0);
        // New target below the level, then the same target again.
        send_command(OP_SET_TARGET, ONE_LEVEL / 4);
        send_command(OP_TICK, '0);
        send_command(OP_SET_TARGET, ONE_LEVEL / 4);
        for (op = OP_UNUSED_FIRST; op != OP_TICK; op++)
            send_command(op, ONE_LEVEL);
        // Full scale, then release with the largest step straight to done.
        send_command(OP_SET_VALUE, ONE_LEVEL);
        send_command(OP_KEY_OFF, '0);
        send_command(OP_TICK, '0);
        send_command(OP_TICK, '0);
        // With a zero attack step the envelope never leaves attack.
        write_register(CFG_ATTACK_STEP, '0);
        send_command(OP_KEY_ON, '0);
        send_command(OP_TICK, '0);
        send_command(OP_TICK, '0);
    endtask

    // Random notes: an optional preset level, key on, a run of ticks, an
    // optional retarget, key off and ticks until done. Between notes come
    // bursts of arbitrary beats and register rewrites. Only commands that
    // the block acts on count toward the quota.
    task automatic test_random_envelopes(input int unsigned send_idle,
                                         input int unsigned recv_idle,
                                         input int unsigned quota);
        int unsigned goal;
        int unsigned roll;
        int unsigned ticks;
        level_t      retarget;
        sender_idle_pct   = send_idle;
        receiver_idle_pct = recv_idle;
        load_settings(random_rate(), random_rate(), random_level(), random_rate());
        goal = commands_sent + quota;
        while (commands_sent < goal)
        begin
            roll = $urandom_range(99);
            if (roll < 6)
            begin
                load_settings(random_rate(), random_rate(), random_level(), random_rate());
            end
            else if (roll < 22)
            begin
                repeat ($urandom_range(1, 4))
                    send_command(OP_W'($urandom_range(0, OP_UNUSED_LAST)), random_level());
            end
            else
            begin
                if ($urandom_range(3) == 0)
                    send_command(OP_SET_VALUE, random_level());
                send_command(OP_KEY_ON, random_level());
                repeat ($urandom_range(1, 20))
                    send_command(OP_TICK, random_level());
                if ($urandom_range(1) == 0)
                begin
                    // A third of the retargets hit the present level exactly.
                    retarget = ($urandom_range(2) == 0) ? env_level : random_level();
                    send_command(OP_SET_TARGET, retarget);
                    repeat ($urandom_range(1, 10))
                        send_command(OP_TICK, random_level());
                end
                send_command(OP_KEY_OFF, random_level());
                ticks = 0;
                while (env_phase != PH_DONE && ticks < 24)
                begin
                    send_command(OP_TICK, random_level());
                    ticks++;
                end
                if ($urandom_range(1) == 0)
                    send_command(OP_TICK, random_level());
            end
        end
    endtask

    // The receiver decides at each falling edge whether to stall.
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= receiver_idle_pct);

    // Every output beat is matched against the oldest owed prediction.
    always @(posedge clk)
    begin : check_output
        envelope_out_t want;
        envelope_out_t got;
        if (m_tvalid && m_tready)
        begin
            got.level = m_tdata[LEVEL_W-1:0];
            got.phase = phase_t'(m_tdata[LEVEL_W +: PHASE_W]);
            results_checked++;
            if (expected_envelope.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTED)
                    $display("Output beat %0d arrived with nothing owed: level %0d phase %0d",
                             results_checked, got.level, got.phase);
            end
            else
            begin
                want = expected_envelope.pop_front();
                if (got.level !== want.level)
                begin
                    failures++;
                    if (failures <= MAX_REPORTED)
                        $display("Output beat %0d level: expected %0d, got %0d",
                                 results_checked, want.level, got.level);
                end
                if (got.phase !== want.phase)
                begin
                    failures++;
                    if (failures <= MAX_REPORTED)
                        $display("Output beat %0d phase: expected %0d, got %0d",
                                 results_checked, want.phase, got.phase);
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run stopped after %0d cycles without finishing", cycle_count);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Sender idles lightly and the receiver heavily first, then the
        // other way round, then both run flat out.
        sender_idle_pct   = 26;
        receiver_idle_pct = 64;
        test_reset_state();
        test_directed_ops();
        test_random_envelopes(26, 64, 340);
        test_random_envelopes(64, 26, 340);
        test_random_envelopes(0, 0, 340);

        wait_until_idle();
        repeat (END_DRAIN_TICKS) @(posedge clk);
        if (expected_envelope.size() != 0)
        begin
            failures++;
            $display("%0d output beats never arrived", expected_envelope.size());
        end

        $display("Sent %0d envelope commands and checked %0d output beats.",
                 commands_sent, results_checked);
        $display("Used %0d register writes across three idling mixes.", register_writes);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/adsr_pkg.sv
rtl/adsr_next_state.sv
rtl/adsr_envelope_generator_core.sv
tb/adsr_envelope_generator_core_test.sv
